@@ hw/rtl/fspa_pkg.sv @@
// Shared types and codes for the fixed slot pool allocator.
// Request kinds, result status codes, controller states and the
// command/status bundles between controller and datapath. No dependencies.
`default_nettype none

package fspa_pkg;

    // Request kind carried in s_tuser
    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_CLEAR = 2'd3
    } fspa_kind_t;

    // Result status carried in m_tuser
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_OUT_OF_MEM  = 2'd1,
        STATUS_OUT_OF_RANGE = 2'd2,
        STATUS_BAD_ADDRESS = 2'd3
    } fspa_status_t;

    // Register index of pool_base on the configuration port
    localparam logic CFG_IDX_POOL_BASE = 1'b0;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_COMMIT,
        ST_RESP
    } fspa_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted request
        logic scan_step;  // examine one 8-slot chunk of the bitmap
        logic mul;        // form slot * slot size
        logic div_step;   // form offset / slot size by reciprocal multiply
        logic commit;     // update bitmap and count, load the result
    } fspa_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        fspa_kind_t kind;
        logic       chunk_found;
        logic       chunk_last;
        logic       span_bad;
    } fspa_stat_t;

endpackage : fspa_pkg

`default_nettype wire

@@ hw/rtl/fspa_ctrl.sv @@
// Controller state machine for the fixed slot pool allocator.
// Sequences decode, bitmap scan, multiply, divide and commit per request.
// Depends on fspa_pkg.
`default_nettype none

module fspa_ctrl
    import fspa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output fspa_cmd_t       cmd,
    input  wire fspa_stat_t stat
);

    fspa_state_t state_reg;
    fspa_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.kind)
                    KIND_ALLOC: state_next = ST_SCAN;
                    KIND_FREE:  state_next = stat.span_bad ? ST_COMMIT : ST_DIV;
                    KIND_QUERY: state_next = ST_COMMIT;
                    KIND_CLEAR: state_next = ST_COMMIT;
                    default:    state_next = ST_COMMIT;
                endcase
            end
            ST_SCAN: begin
                if (stat.chunk_found) begin
                    state_next = ST_MUL;
                end else if (stat.chunk_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_MUL: begin
                state_next = ST_COMMIT;
            end
            ST_DIV: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                // hold off requests while reset is asserted
                in_ready = aresetn;
                cmd.load = in_valid && aresetn;
            end
            ST_DECODE: begin
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
            end
            ST_RESP: begin
                out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule : fspa_ctrl

`default_nettype wire

@@ hw/rtl/fspa_datapath.sv @@
// Datapath of the fixed slot pool allocator: used bitmap, used count,
// pool base register, chunk scanner, slot divider and result registers.
// Depends on fspa_pkg.
`default_nettype none

module fspa_datapath
    import fspa_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_BYTES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    output logic      [31:0] pool_base,
    // request
    input  wire fspa_kind_t  in_kind,
    input  wire logic [31:0] in_addr,
    input  wire logic [7:0]  in_slot_index,
    // control
    input  wire fspa_cmd_t   cmd,
    output fspa_stat_t       stat,
    // result
    output fspa_status_t     out_status,
    output logic      [31:0] out_addr,
    output logic      [3:0]  out_slot,
    output logic             out_free,
    output logic      [4:0]  out_count
);

    localparam int SW     = $clog2(SLOT_COUNT);
    localparam int CNTW   = $clog2(SLOT_COUNT + 1);
    localparam int NCHUNK = (SLOT_COUNT + 7) / 8;
    localparam int PW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SPAN   = SLOT_COUNT * SLOT_BYTES;
    localparam int RW     = $clog2(SPAN);
    // Reciprocal of the slot size, exact for every offset below 2**RW
    localparam int     LD    = $clog2(SLOT_BYTES);
    localparam int     RS    = RW + LD;
    localparam int     PRW   = 2 * RW + 1;
    localparam longint RECIP = ((longint'(1) << RS) + SLOT_BYTES - 1) / SLOT_BYTES;

    // State and working registers
    logic [SLOT_COUNT-1:0] used_reg;
    logic [SLOT_COUNT-1:0] used_next;
    logic [CNTW-1:0]       count_reg;
    logic [CNTW-1:0]       count_next;
    logic [31:0]           pool_base_reg;

    fspa_kind_t            kind_reg;
    logic [7:0]            qidx_reg;
    logic                  span_bad_reg;
    logic                  full_reg;
    logic [PW-1:0]         scan_ptr_reg;
    logic [SW-1:0]         slot_reg;
    logic [31:0]           prod_reg;
    logic [RW-1:0]         off_reg;

    fspa_status_t          res_status_reg;
    logic [31:0]           res_addr_reg;
    logic [3:0]            res_slot_reg;
    logic                  res_free_reg;
    logic [4:0]            res_count_reg;

    // Scan and divide helpers
    logic [NCHUNK*8-1:0]   used_pad;
    logic [7:0]            chunk;
    logic [2:0]            chunk_enc;
    logic [SW-1:0]         slot_found;
    logic [31:0]           offset;
    logic [PRW-1:0]        quot_prod;
    logic                  qidx_bad;

    // Commit results
    fspa_status_t          c_status;
    logic [31:0]           c_addr;
    logic [3:0]            c_slot;
    logic                  c_free;

    // Pool base register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= '0;
        end else if (cfg_we) begin
            pool_base_reg <= cfg_wdata;
        end
    end

    assign pool_base = pool_base_reg;

    // Pad the bitmap to whole chunks; slots past the pool read as used
    always_comb begin
        used_pad = '1;
        used_pad[SLOT_COUNT-1:0] = used_reg;
    end

    assign chunk = used_pad[scan_ptr_reg*8 +: 8];

    // Lowest free slot inside the current chunk
    always_comb begin
        chunk_enc = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!chunk[i]) begin
                chunk_enc = 3'(i);
            end
        end
    end

    assign slot_found = SW'({scan_ptr_reg, chunk_enc});

    assign offset    = in_addr - pool_base_reg;
    assign quot_prod = PRW'(off_reg) * PRW'(RECIP);
    assign qidx_bad  = {1'b0, qidx_reg} >= 9'(SLOT_COUNT);

    // Status to controller
    always_comb begin
        stat.kind        = kind_reg;
        stat.chunk_found = ~&chunk;
        stat.chunk_last  = scan_ptr_reg == PW'(NCHUNK - 1);
        stat.span_bad    = span_bad_reg;
    end

    // Request capture, scan, multiply and divide steps
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg     <= in_kind;
            qidx_reg     <= in_slot_index;
            span_bad_reg <= offset >= 32'(SPAN);
            off_reg      <= offset[RW-1:0];
            full_reg     <= 1'b0;
            scan_ptr_reg <= '0;
            slot_reg     <= '0;
        end
        if (cmd.scan_step) begin
            if (~&chunk) begin
                slot_reg <= slot_found;
            end else if (scan_ptr_reg == PW'(NCHUNK - 1)) begin
                full_reg <= 1'b1;
            end else begin
                scan_ptr_reg <= scan_ptr_reg + PW'(1);
            end
        end
        if (cmd.mul) begin
            prod_reg <= 32'(slot_reg) * 32'(SLOT_BYTES);
        end
        // Slot holding the address: high bits of offset times the reciprocal
        if (cmd.div_step) begin
            slot_reg <= quot_prod[RS +: SW];
        end
    end

    // Commit: new bitmap, new count and the result fields
    always_comb begin
        used_next  = used_reg;
        count_next = count_reg;
        c_status   = STATUS_OK;
        c_addr     = '0;
        c_slot     = '0;
        c_free     = 1'b0;
        case (kind_reg)
            KIND_ALLOC: begin
                if (full_reg) begin
                    c_status = STATUS_OUT_OF_MEM;
                end else begin
                    used_next[slot_reg] = 1'b1;
                    count_next = count_reg + CNTW'(1);
                    c_addr     = pool_base_reg + prod_reg;
                    c_slot     = 4'(slot_reg);
                end
            end
            KIND_FREE: begin
                if (span_bad_reg) begin
                    c_status = STATUS_BAD_ADDRESS;
                end else begin
                    if (used_reg[slot_reg]) begin
                        used_next[slot_reg] = 1'b0;
                        count_next = count_reg - CNTW'(1);
                    end
                    c_slot = 4'(slot_reg);
                end
            end
            KIND_QUERY: begin
                if (qidx_bad) begin
                    c_status = STATUS_OUT_OF_RANGE;
                end else begin
                    c_free = ~used_reg[qidx_reg[SW-1:0]];
                end
            end
            KIND_CLEAR: begin
                used_next  = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    // Bitmap and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.commit) begin
            used_reg  <= used_next;
            count_reg <= count_next;
        end
    end

    // Result registers, held until taken
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_status_reg <= c_status;
            res_addr_reg   <= c_addr;
            res_slot_reg   <= c_slot;
            res_free_reg   <= c_free;
            res_count_reg  <= 5'(count_next);
        end
    end

    assign out_status = res_status_reg;
    assign out_addr   = res_addr_reg;
    assign out_slot   = res_slot_reg;
    assign out_free   = res_free_reg;
    assign out_count  = res_count_reg;

endmodule : fspa_datapath

`default_nettype wire

@@ hw/rtl/fixed_slot_pool_allocator_unit.sv @@
// Top level of the fixed slot pool allocator: stream ports, APB register
// port, controller and datapath. Depends on fspa_pkg, fspa_ctrl, fspa_datapath.
//
// Usage:
//   Requests enter on the s_ channel, one result per request leaves on m_.
//   s_tuser selects allocate, free by address, query slot or clear all.
//   pool_base is written over APB while no request is in flight.
//   One request is in the block at a time. After the accepting edge, query
//   and clear pass through decode and commit; free passes through decode,
//   a reciprocal multiply for the slot and commit, or decode and commit for
//   an address outside the pool; allocate passes through decode, a scan of
//   the used bitmap (one 8-slot chunk per cycle) up to the first free slot,
//   the multiply of slot by slot size and commit, or a scan of every chunk
//   and commit when the pool is full; m_tvalid rises once commit is done.
//   s_tready rises the cycle after the result is taken.
//   A stalled receiver holds the result in the output registers and keeps
//   s_tready low until m_tready is seen.
//   Reset frees all slots, clears the used count and sets pool_base to zero;
//   s_tready stays low while reset is asserted.
`default_nettype none

module fixed_slot_pool_allocator_unit
    import fspa_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_BYTES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // byte_address[31:0], slot_index[39:32]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // granted_address[31:0], granted_slot[35:32],
                                        // slot_is_free[36], used_count[41:37], zero[47:42]
    output logic      [1:0]  m_tuser,   // status[1:0]
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    fspa_cmd_t    cmd;
    fspa_stat_t   stat;
    fspa_status_t out_status;
    logic [31:0]  out_addr;
    logic [3:0]   out_slot;
    logic         out_free;
    logic [4:0]   out_count;
    logic [31:0]  pool_base;
    logic         cfg_we;

    // Register access decode
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == CFG_IDX_POOL_BASE);
    assign prdata = (paddr[2] == CFG_IDX_POOL_BASE) ? pool_base : 32'd0;

    fspa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    fspa_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (pwdata),
        .pool_base     (pool_base),
        .in_kind       (fspa_kind_t'(s_tuser)),
        .in_addr       (s_tdata[31:0]),
        .in_slot_index (s_tdata[39:32]),
        .cmd           (cmd),
        .stat          (stat),
        .out_status    (out_status),
        .out_addr      (out_addr),
        .out_slot      (out_slot),
        .out_free      (out_free),
        .out_count     (out_count)
    );

    // Pack the result
    assign m_tdata = {6'd0, out_count, out_free, out_slot, out_addr};
    assign m_tuser = out_status;

endmodule : fixed_slot_pool_allocator_unit

`default_nettype wire
